// ----- design/gjinv_pkg.sv -----
// Shared types and constants for the 4x4 Gauss-Jordan matrix inverter.
// Used by the top level only; depends on nothing else.
`default_nettype none

package gjinv_pkg;

  // Matrix geometry and number formats.
  localparam int unsigned Dim       = 4;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned IntShift  = 32 - FracBits;
  localparam int unsigned NumElems  = Dim * Dim;
  localparam int unsigned WordW     = 64;
  localparam int unsigned WramDepth = 2 * Dim * Dim;
  localparam int unsigned WramAw    = $clog2(WramDepth);
  localparam int unsigned ThrW      = 31;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_COPY,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_CHECK,
    ST_PIV_RD,
    ST_DIV_INIT,
    ST_DIV,
    ST_SCL_RD,
    ST_SCL_OP,
    ST_MUL,
    ST_MUL_DONE,
    ST_ELIM_ROW,
    ST_ELIM_F,
    ST_ELIM_RD1,
    ST_ELIM_OP,
    ST_ELIM_RD2,
    ST_ELIM_WR,
    ST_NEXT_COL,
    ST_OUT_RD,
    ST_OUT_CV,
    ST_OUT_WAIT
  } gj_state_e;

endpackage

`default_nettype wire

// ----- design/gjinv_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; sized by its WIDTH and DEPTH parameters.
`default_nettype none

module gjinv_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/matrix4_inverse_gauss_jordan_top.sv -----
// Top level of the 4x4 matrix inverter: loader, sequencer, shared multiply,
// divide and subtract datapath. Depends on gjinv_pkg and gjinv_ram.
//
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------
// in       | in        | in_valid_i / in_stall_o| element_value_i, element_index_i
// out      | out       | out_valid_o/out_stall_i| inverse_value_o, result_index_o,
//          |           |                        | singular_o, saturated_o, last_o
// cfg      | in        | cfg_valid_i/cfg_ready_o| cfg_data_i (pivot threshold)
//
// Every accepted element is stored in its slot; index 15 also starts a run:
// a copy into the working RAM, then per column a pivot search, a restoring
// reciprocal, row scaling and multiply-subtract through one 32x32 multiplier
// that forms each product from four partial products. Each result beat then
// passes through a RAM read, rounding and the output register. The input is
// stalled for the whole run and until the last beat is taken; out_stall_i
// simply holds the output register. Reset clears the sequencer, the threshold
// and the output valid; matrix storage is not cleared.
`default_nettype none

module matrix4_inverse_gauss_jordan_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Element input.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] element_value_i,
  input  wire logic [3:0]  element_index_i,
  // Result output.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      inverse_value_o,
  output logic [3:0]       result_index_o,
  output logic             singular_o,
  output logic             saturated_o,
  output logic             last_o,
  // Threshold write.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [30:0] cfg_data_i
);

  localparam logic [63:0] Int64Max = {1'b0, {63{1'b1}}};
  localparam logic [63:0] Int64Min = {1'b1, 63'd0};
  localparam logic [31:0] Int32Max = {1'b0, {31{1'b1}}};
  localparam logic [31:0] Int32Min = {1'b1, 31'd0};

  // Two's-complement magnitude of a Q32.32 word.
  function automatic logic [63:0] mag64(input logic [63:0] x);
    mag64 = x[63] ? (64'd0 - x) : x;
  endfunction

  // Signed result from sign and magnitude, saturated to the int64 range.
  function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] m,
                                           input logic ovf);
    if (!neg) begin
      from_mag = (ovf || m[63]) ? Int64Max : m;
    end else begin
      from_mag = (ovf || m[63]) ? Int64Min : (64'd0 - m);
    end
  endfunction

  // Saturating subtraction.
  function automatic logic [63:0] qsub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] diff;
    diff = {a[63], a} - {b[63], b};
    if (diff[64] != diff[63]) begin
      qsub = diff[64] ? Int64Min : Int64Max;
    end else begin
      qsub = diff[63:0];
    end
  endfunction

  // State and registers.
  gjinv_pkg::gj_state_e state_q, state_d;

  logic [gjinv_pkg::ThrW-1:0] thr_q;
  logic [31:0]  store_q [gjinv_pkg::NumElems];
  logic [1:0]   map_q [gjinv_pkg::Dim];
  logic [4:0]   copy_cnt_q;
  logic [1:0]   col_q;
  logic [1:0]   row_q;
  logic [2:0]   j_q;
  logic [1:0]   prow_q;
  logic [63:0]  best_q;
  logic         piv_neg_q;
  logic [63:0]  dvs_q;
  logic [63:0]  rem_q;
  logic [64:0]  quo_q;
  logic [6:0]   dcnt_q;
  logic [63:0]  recip_q;
  logic [63:0]  factor_q;
  logic [63:0]  ua_q, ub_q;
  logic         mneg_q;
  logic [1:0]   mk_q;
  logic [127:0] acc_q;
  logic         mul_elim_q;
  logic [63:0]  prod_q;
  logic [3:0]   ok_q;
  logic         out_valid_q;
  logic [31:0]  out_value_q;
  logic [3:0]   out_index_q;
  logic         out_sing_q;
  logic         out_sat_q;
  logic         out_last_q;

  // RAM ports.
  logic                           wr_en;
  logic [gjinv_pkg::WramAw-1:0]   wr_addr;
  logic [63:0]                    wr_data;
  logic [gjinv_pkg::WramAw-1:0]   rd_addr;
  logic [63:0]                    rd_data;

  gjinv_ram #(
    .WIDTH(gjinv_pkg::WordW),
    .DEPTH(gjinv_pkg::WramDepth)
  ) u_wram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // Handshakes.
  logic in_acc, out_acc;
  assign in_stall_o  = (state_q != gjinv_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == gjinv_pkg::ST_IDLE);
  assign out_acc     = out_valid_q && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o     = out_valid_q;
  assign inverse_value_o = out_value_q;
  assign result_index_o  = out_index_q;
  assign singular_o      = out_sing_q;
  assign saturated_o     = out_sat_q;
  assign last_o          = out_last_q;

  // Copy data: left half from the element store, right half the identity.
  logic [31:0] copy_elem;
  logic [63:0] copy_word;
  assign copy_elem = store_q[{copy_cnt_q[4:3], copy_cnt_q[1:0]}];
  always_comb begin
    if (!copy_cnt_q[2]) begin
      copy_word = {{gjinv_pkg::IntShift{copy_elem[31]}}, copy_elem,
                   {gjinv_pkg::IntShift{1'b0}}};
    end else if (copy_cnt_q[1:0] == copy_cnt_q[4:3]) begin
      copy_word = 64'h0000_0001_0000_0000;
    end else begin
      copy_word = 64'd0;
    end
  end

  // Pivot search helpers.
  logic [63:0] rd_mag;
  logic [63:0] limit;
  assign rd_mag = mag64(rd_data);
  assign limit  = {{(64 - gjinv_pkg::ThrW - gjinv_pkg::IntShift){1'b0}}, thr_q,
                   {gjinv_pkg::IntShift{1'b0}}};

  // Restoring divider step for floor(2^64 / m).
  logic [64:0] div_shift;
  logic        div_ge;
  assign div_shift = {rem_q, (dcnt_q == 7'd0)};
  assign div_ge    = (div_shift >= {1'b0, dvs_q});

  // Shared 32x32 multiplier, one partial product a cycle.
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  assign pa = mk_q[1] ? ua_q[63:32] : ua_q[31:0];
  assign pb = mk_q[0] ? ub_q[63:32] : ub_q[31:0];
  assign pp = pa * pb;
  always_comb begin
    case (mk_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // Rounded, saturated product taken from the accumulator.
  logic [63:0] mul_res;
  assign mul_res = from_mag(mneg_q, acc_q[95:32], |acc_q[127:96]);

  // Output conversion: round half up and saturate to 32 bits.
  logic [48:0] ov_sum;
  logic        ov_clip;
  logic [31:0] ov_val;
  assign ov_sum  = {rd_data[63], rd_data[63:gjinv_pkg::IntShift]}
                 + {48'd0, rd_data[gjinv_pkg::IntShift-1]};
  assign ov_clip = !((ov_sum[48:31] == 18'd0) || (ov_sum[48:31] == {18{1'b1}}));
  assign ov_val  = ov_clip ? (ov_sum[48] ? Int32Min : Int32Max) : ov_sum[31:0];

  // Next state and RAM control.
  always_comb begin
    state_d = state_q;
    wr_en   = 1'b0;
    wr_addr = {map_q[col_q], j_q};
    wr_data = mul_res;
    rd_addr = {map_q[row_q], 1'b0, col_q};
    case (state_q)
      gjinv_pkg::ST_IDLE: begin
        if (in_acc && (element_index_i == 4'(gjinv_pkg::NumElems - 1))) begin
          state_d = gjinv_pkg::ST_COPY;
        end
      end
      gjinv_pkg::ST_COPY: begin
        wr_en   = 1'b1;
        wr_addr = copy_cnt_q;
        wr_data = copy_word;
        if (copy_cnt_q == 5'(gjinv_pkg::WramDepth - 1)) begin
          state_d = gjinv_pkg::ST_SRCH_RD;
        end
      end
      gjinv_pkg::ST_SRCH_RD: begin
        state_d = gjinv_pkg::ST_SRCH_CMP;
      end
      gjinv_pkg::ST_SRCH_CMP: begin
        state_d = (row_q == 2'd3) ? gjinv_pkg::ST_CHECK : gjinv_pkg::ST_SRCH_RD;
      end
      gjinv_pkg::ST_CHECK: begin
        state_d = (best_q <= limit) ? gjinv_pkg::ST_OUT_WAIT : gjinv_pkg::ST_PIV_RD;
      end
      gjinv_pkg::ST_PIV_RD: begin
        rd_addr = {map_q[col_q], 1'b0, col_q};
        state_d = gjinv_pkg::ST_DIV_INIT;
      end
      gjinv_pkg::ST_DIV_INIT: begin
        state_d = (rd_mag <= 64'd1) ? gjinv_pkg::ST_SCL_RD : gjinv_pkg::ST_DIV;
      end
      gjinv_pkg::ST_DIV: begin
        if (dcnt_q == 7'd64) begin
          state_d = gjinv_pkg::ST_SCL_RD;
        end
      end
      gjinv_pkg::ST_SCL_RD: begin
        rd_addr = {map_q[col_q], j_q};
        state_d = gjinv_pkg::ST_SCL_OP;
      end
      gjinv_pkg::ST_SCL_OP: begin
        state_d = gjinv_pkg::ST_MUL;
      end
      gjinv_pkg::ST_MUL: begin
        if (mk_q == 2'd3) begin
          state_d = gjinv_pkg::ST_MUL_DONE;
        end
      end
      gjinv_pkg::ST_MUL_DONE: begin
        if (mul_elim_q) begin
          state_d = gjinv_pkg::ST_ELIM_RD2;
        end else begin
          wr_en   = 1'b1;
          wr_addr = {map_q[col_q], j_q};
          state_d = (j_q == 3'd7) ? gjinv_pkg::ST_ELIM_ROW : gjinv_pkg::ST_SCL_RD;
        end
      end
      gjinv_pkg::ST_ELIM_ROW: begin
        rd_addr = {map_q[row_q], 1'b0, col_q};
        if (row_q == col_q) begin
          state_d = (row_q == 2'd3) ? gjinv_pkg::ST_NEXT_COL : gjinv_pkg::ST_ELIM_ROW;
        end else begin
          state_d = gjinv_pkg::ST_ELIM_F;
        end
      end
      gjinv_pkg::ST_ELIM_F: begin
        state_d = gjinv_pkg::ST_ELIM_RD1;
      end
      gjinv_pkg::ST_ELIM_RD1: begin
        rd_addr = {map_q[col_q], j_q};
        state_d = gjinv_pkg::ST_ELIM_OP;
      end
      gjinv_pkg::ST_ELIM_OP: begin
        state_d = gjinv_pkg::ST_MUL;
      end
      gjinv_pkg::ST_ELIM_RD2: begin
        rd_addr = {map_q[row_q], j_q};
        state_d = gjinv_pkg::ST_ELIM_WR;
      end
      gjinv_pkg::ST_ELIM_WR: begin
        wr_en   = 1'b1;
        wr_addr = {map_q[row_q], j_q};
        wr_data = qsub(rd_data, prod_q);
        if (j_q == 3'd7) begin
          state_d = (row_q == 2'd3) ? gjinv_pkg::ST_NEXT_COL : gjinv_pkg::ST_ELIM_ROW;
        end else begin
          state_d = gjinv_pkg::ST_ELIM_RD1;
        end
      end
      gjinv_pkg::ST_NEXT_COL: begin
        state_d = (col_q == 2'd3) ? gjinv_pkg::ST_OUT_RD : gjinv_pkg::ST_SRCH_RD;
      end
      gjinv_pkg::ST_OUT_RD: begin
        rd_addr = {map_q[ok_q[3:2]], 1'b1, ok_q[1:0]};
        state_d = gjinv_pkg::ST_OUT_CV;
      end
      gjinv_pkg::ST_OUT_CV: begin
        state_d = gjinv_pkg::ST_OUT_WAIT;
      end
      gjinv_pkg::ST_OUT_WAIT: begin
        if (out_acc) begin
          state_d = out_last_q ? gjinv_pkg::ST_IDLE : gjinv_pkg::ST_OUT_RD;
        end
      end
      default: begin
        state_d = gjinv_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gjinv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Threshold register and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if ((state_q == gjinv_pkg::ST_OUT_CV) ||
          ((state_q == gjinv_pkg::ST_CHECK) && (best_q <= limit))) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Element store: each beat lands in its row-major slot.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      store_q[element_index_i] <= element_value_i;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      gjinv_pkg::ST_IDLE: begin
        copy_cnt_q <= '0;
        col_q      <= '0;
        row_q      <= '0;
        for (int r = 0; r < gjinv_pkg::Dim; r++) begin
          map_q[r] <= 2'(r);
        end
      end
      gjinv_pkg::ST_COPY: begin
        copy_cnt_q <= copy_cnt_q + 5'd1;
      end
      gjinv_pkg::ST_SRCH_CMP: begin
        if ((row_q == col_q) || (rd_mag > best_q)) begin
          best_q <= rd_mag;
          prow_q <= row_q;
        end
        row_q <= row_q + 2'd1;
      end
      gjinv_pkg::ST_CHECK: begin
        // Swap rows by exchanging their physical addresses.
        if (prow_q != col_q) begin
          map_q[col_q]  <= map_q[prow_q];
          map_q[prow_q] <= map_q[col_q];
        end
        out_value_q   <= '0;
        out_index_q   <= '0;
        out_sing_q    <= 1'b1;
        out_sat_q     <= 1'b0;
        out_last_q    <= 1'b1;
      end
      gjinv_pkg::ST_DIV_INIT: begin
        piv_neg_q <= rd_data[63];
        dvs_q     <= rd_mag;
        rem_q     <= '0;
        quo_q     <= '0;
        dcnt_q    <= '0;
        j_q       <= '0;
        recip_q   <= rd_data[63] ? Int64Min : Int64Max;
      end
      gjinv_pkg::ST_DIV: begin
        rem_q  <= div_ge ? 64'(div_shift - {1'b0, dvs_q}) : div_shift[63:0];
        quo_q  <= {quo_q[63:0], div_ge};
        dcnt_q <= dcnt_q + 7'd1;
        // The final quotient bit is the one decided in this step.
        if (dcnt_q == 7'd64) begin
          recip_q <= from_mag(piv_neg_q, {quo_q[62:0], div_ge}, quo_q[63]);
        end
      end
      gjinv_pkg::ST_SCL_OP: begin
        ua_q       <= rd_mag;
        ub_q       <= mag64(recip_q);
        mneg_q     <= rd_data[63] ^ recip_q[63];
        mk_q       <= '0;
        acc_q      <= 128'h8000_0000;
        mul_elim_q <= 1'b0;
      end
      gjinv_pkg::ST_MUL: begin
        acc_q <= acc_q + pp_sh;
        mk_q  <= mk_q + 2'd1;
      end
      gjinv_pkg::ST_MUL_DONE: begin
        prod_q <= mul_res;
        if (!mul_elim_q) begin
          j_q <= j_q + 3'd1;
          if (j_q == 3'd7) begin
            row_q <= '0;
          end
        end
      end
      gjinv_pkg::ST_ELIM_ROW: begin
        if (row_q == col_q) begin
          row_q <= row_q + 2'd1;
        end
      end
      gjinv_pkg::ST_ELIM_F: begin
        factor_q <= rd_data;
        j_q      <= '0;
      end
      gjinv_pkg::ST_ELIM_OP: begin
        ua_q       <= mag64(factor_q);
        ub_q       <= rd_mag;
        mneg_q     <= factor_q[63] ^ rd_data[63];
        mk_q       <= '0;
        acc_q      <= 128'h8000_0000;
        mul_elim_q <= 1'b1;
      end
      gjinv_pkg::ST_ELIM_WR: begin
        j_q <= j_q + 3'd1;
        if (j_q == 3'd7) begin
          row_q <= row_q + 2'd1;
        end
      end
      gjinv_pkg::ST_NEXT_COL: begin
        col_q <= col_q + 2'd1;
        row_q <= col_q + 2'd1;
        ok_q  <= '0;
      end
      gjinv_pkg::ST_OUT_CV: begin
        out_value_q <= ov_val;
        out_index_q <= ok_q;
        out_sing_q  <= 1'b0;
        out_sat_q   <= ov_clip;
        out_last_q  <= (ok_q == 4'(gjinv_pkg::NumElems - 1));
        ok_q        <= ok_q + 4'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
